// ===== rtl/hdlf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character codes and glyph lookup for the hex dump line formatter.
package hdlf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 3;

    // Reset value of the bytes-per-line register.
    localparam logic [BYTE_W-1:0] COLS_RESET = 8'd16;

    // ASCII codes besides the hex digits.
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

    // Character positions inside the text of one byte.
    localparam logic [LEN_W-1:0] SLOT_HI    = 3'd0;
    localparam logic [LEN_W-1:0] SLOT_LO    = 3'd1;
    localparam logic [LEN_W-1:0] SLOT_SPACE = 3'd2;
    localparam logic [LEN_W-1:0] SLOT_CR    = 3'd3;
    localparam logic [LEN_W-1:0] SLOT_LF    = 3'd4;

    // Number of characters produced by one byte.
    localparam logic [LEN_W-1:0] LEN_LAST  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_SPACE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_BREAK = 3'd5;

    // One decoded byte, waiting to be sent out one character per cycle while the output is not stalled.
    typedef struct packed {
        logic [BYTE_W-1:0] hi_char;
        logic [BYTE_W-1:0] lo_char;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_item;

    // Upper-case hex digit for a nibble.
    function automatic logic [BYTE_W-1:0] hex_glyph(input logic [3:0] nib);
        logic [BYTE_W-1:0] ext;
        ext = {4'b0000, nib};
        if (nib < 4'd10) begin
            hex_glyph = 8'h30 + ext;
        end else begin
            hex_glyph = 8'h37 + ext;
        end
    endfunction

endpackage

// ===== rtl/hdlf_encode.sv =====
`timescale 1ns / 1ps
// Byte decoder: hex digits, character count and next column position for one byte.
module hdlf_encode (
    input  logic [7:0]     i_data,
    input  logic           i_last,
    input  logic [7:0]     i_col,
    input  logic [7:0]     i_cols,
    output hdlf_pkg::t_item o_item,
    output logic [7:0]     o_col_next
);
    import hdlf_pkg::*;

    logic [8:0] col_inc;
    logic [8:0] limit;
    logic       line_brk;

    // Zero columns means 256 bytes per line.
    assign col_inc  = {1'b0, i_col} + 9'd1;
    assign limit    = (i_cols == 8'd0) ? 9'd256 : {1'b0, i_cols};
    assign line_brk = (col_inc >= limit);

    always_comb begin
        o_item.hi_char = hex_glyph(i_data[7:4]);
        o_item.lo_char = hex_glyph(i_data[3:0]);
        o_item.last    = i_last;
        priority if (i_last) begin
            o_item.len = LEN_LAST;
            o_col_next = 8'd0;
        end else if (line_brk) begin
            o_item.len = LEN_BREAK;
            o_col_next = 8'd0;
        end else begin
            o_item.len = LEN_SPACE;
            o_col_next = col_inc[7:0];
        end
    end

endmodule

// ===== rtl/hex_dump_line_formatter.sv =====
`timescale 1ns / 1ps
// Top level of the hex dump line formatter: byte intake, character sequencer, output register.
//
// Usage:
//   Slave stream: one raw byte per transfer on tdata[7:0], tlast marks the last
//   byte of a message. Master stream: one ASCII character per transfer on
//   tdata[7:0]; tuser[0] flags the final character made for one input byte,
//   tlast flags the final character of the whole message text.
//   Config channel: a transfer on i_cfg_valid/o_cfg_ready writes bytes per line
//   (0 means 256). Write it only while the block is idle.
// Path: a byte is taken into the item holding register, and its characters pass one
//   by one through the output register to the master stream.
// Throughput: one character per cycle unless the receiver stalls; a byte makes 2
//   characters (last byte of a message), 3 (byte followed by a space) or 5 (space,
//   CR, LF at a line end). The single-character output port sets that rate; the next
//   byte is taken in the cycle the previous byte's final character enters the
//   output register, so characters of consecutive bytes follow without gaps.
// Reset: synchronous, active low; clears the column position, empties the item
//   holding register and the output register, and sets bytes per line to 16.
// Stall: while the receiver holds tready low the output character holds, the
//   holding register fills and then o_s_axis_tready drops until space frees up.
module hex_dump_line_formatter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Config write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,      // columns_per_line
    // Byte input stream
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [7:0] data_byte
    input  logic       i_s_axis_tlast,  // last_byte
    // Character output stream
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,  // [7:0] text_char
    output logic       o_m_axis_tuser,  // [0] run_last
    output logic       o_m_axis_tlast   // text_end
);
    import hdlf_pkg::*;

    // Configuration and column state
    logic [7:0] r_cols;
    logic [7:0] r_col;
    logic [7:0] n_col;

    // Item holding register and character pointer
    t_item      r_item;
    t_item      n_item;
    logic       r_busy;
    logic [2:0] r_slot;

    // Output register
    logic       r_ovalid;
    logic [7:0] r_ochar;
    logic       r_orun;
    logic       r_oend;

    logic       out_free;
    logic       move;
    logic       item_done;
    logic       accept;
    logic [7:0] slot_char;

    hdlf_encode u_encode (
        .i_data     (i_s_axis_tdata),
        .i_last     (i_s_axis_tlast),
        .i_col      (r_col),
        .i_cols     (r_cols),
        .o_item     (n_item),
        .o_col_next (n_col)
    );

    // Advance one character whenever the output register is empty or being drained.
    assign out_free  = !r_ovalid || i_m_axis_tready;
    assign move      = r_busy && out_free;
    assign item_done = move && (r_slot == (r_item.len - 3'd1));
    assign accept    = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = !r_busy || item_done;
    assign o_cfg_ready     = 1'b1;

    // Pick the character at the current position of the held item.
    always_comb begin
        unique case (r_slot)
            SLOT_HI:    slot_char = r_item.hi_char;
            SLOT_LO:    slot_char = r_item.lo_char;
            SLOT_SPACE: slot_char = CHAR_SPACE;
            SLOT_CR:    slot_char = CHAR_CR;
            SLOT_LF:    slot_char = CHAR_LF;
            default:    slot_char = CHAR_SPACE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= COLS_RESET;
            r_col    <= 8'd0;
            r_busy   <= 1'b0;
            r_slot   <= SLOT_HI;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cols <= i_cfg_data;
            end
            // Take the new byte; the column count moves at intake.
            if (accept) begin
                r_col  <= n_col;
                r_busy <= 1'b1;
                r_slot <= SLOT_HI;
            end else if (item_done) begin
                r_busy <= 1'b0;
            end else if (move) begin
                r_slot <= r_slot + 3'd1;
            end
            if (move) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
        if (move) begin
            r_ochar <= slot_char;
            r_orun  <= item_done;
            r_oend  <= item_done && r_item.last;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_ochar;
    assign o_m_axis_tuser  = r_orun;
    assign o_m_axis_tlast  = r_oend;

endmodule

// ===== rtl/hdlf_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the hex dump line formatter, bound to the top level.
module hdlf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tuser,
    input logic       o_m_axis_tlast
);
    import hdlf_pkg::*;

    // Hold the character while the receiver stalls.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output changed during stall");

    // End of message text is always the end of a byte's run.
    a_end_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser)
        else $error("text end without run end");

    // Only hex digits, space, CR and LF leave the block.
    a_legal_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tdata >= 8'h30) && (o_m_axis_tdata <= 8'h39)) ||
            ((o_m_axis_tdata >= 8'h41) && (o_m_axis_tdata <= 8'h46)) ||
            (o_m_axis_tdata == CHAR_SPACE) || (o_m_axis_tdata == CHAR_CR) ||
            (o_m_axis_tdata == CHAR_LF))
        else $error("illegal character");

    // A CR transfer is followed at once by an LF.
    a_cr_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && (o_m_axis_tdata == CHAR_CR) |=>
            o_m_axis_tvalid && (o_m_axis_tdata == CHAR_LF))
        else $error("CR not followed by LF");

    // LF closes a byte's run but never the message.
    a_lf_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata == CHAR_LF) |->
            o_m_axis_tuser && !o_m_axis_tlast)
        else $error("LF flags wrong");

endmodule

bind hex_dump_line_formatter hdlf_checker u_hdlf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== verif/tb_hex_dump_line_formatter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the hex dump line formatter: directed and random byte streams.
module tb_hex_dump_line_formatter;
    import hdlf_pkg::*;

    // One character of dump text as it leaves the block.
    typedef struct {
        logic [7:0] ch;
        logic       run_last;
        logic       text_end;
    } t_text_char;

    localparam logic [8*16-1:0] DIGIT_GLYPHS = "0123456789ABCDEF";

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;
    logic       i_s_axis_tlast;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tuser;
    logic       o_m_axis_tlast;

    // Shadow copy of the block's register and line position.
    logic [7:0] cols_per_line;
    logic [7:0] line_pos;

    t_text_char dump_text_q[$];

    int  mismatches;
    int  bytes_sent;
    int  chars_checked;
    int  cfg_writes;
    bit  idle_on;

    hex_dump_line_formatter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [7:0] digit_char(input logic [3:0] nib);
        return DIGIT_GLYPHS[(15 - nib) * 8 +: 8];
    endfunction

    function automatic t_text_char mk_char(input logic [7:0] c, input logic rl,
                                           input logic te);
        t_text_char t;
        t.ch       = c;
        t.run_last = rl;
        t.text_end = te;
        return t;
    endfunction

    // Append the text one byte produces and advance the line position.
    function automatic void predict_byte_text(input logic [7:0] b, input logic last);
        logic [8:0] limit;
        logic [8:0] next_pos;
        limit    = (cols_per_line == 8'd0) ? 9'd256 : {1'b0, cols_per_line};
        next_pos = {1'b0, line_pos} + 9'd1;
        dump_text_q.push_back(mk_char(digit_char(b[7:4]), 1'b0, 1'b0));
        if (last) begin
            dump_text_q.push_back(mk_char(digit_char(b[3:0]), 1'b1, 1'b1));
            line_pos = 8'd0;
        end else begin
            dump_text_q.push_back(mk_char(digit_char(b[3:0]), 1'b0, 1'b0));
            if (next_pos >= limit) begin
                dump_text_q.push_back(mk_char(CHAR_SPACE, 1'b0, 1'b0));
                dump_text_q.push_back(mk_char(CHAR_CR, 1'b0, 1'b0));
                dump_text_q.push_back(mk_char(CHAR_LF, 1'b1, 1'b0));
                line_pos = 8'd0;
            end else begin
                dump_text_q.push_back(mk_char(CHAR_SPACE, 1'b1, 1'b0));
                line_pos = next_pos[7:0];
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Receiver side: random back-pressure, changed at the falling edge.
    always @(negedge i_clk) begin
        i_m_axis_tready <= !idle_on || ($urandom_range(99) >= 16);
    end

    // Compare each output transfer with the oldest predicted character.
    always @(posedge i_clk) begin : check_text
        t_text_char e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (dump_text_q.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h", o_m_axis_tdata));
            end else begin
                e = dump_text_q.pop_front();
                chars_checked++;
                if (o_m_axis_tdata !== e.ch)
                    report_mismatch($sformatf("text_char got 0x%02h exp 0x%02h",
                                              o_m_axis_tdata, e.ch));
                if (o_m_axis_tuser !== e.run_last)
                    report_mismatch($sformatf("run_last got %b exp %b on 0x%02h",
                                              o_m_axis_tuser, e.run_last, e.ch));
                if (o_m_axis_tlast !== e.text_end)
                    report_mismatch($sformatf("text_end got %b exp %b on 0x%02h",
                                              o_m_axis_tlast, e.text_end, e.ch));
            end
        end
    end

    // Send one byte; entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (idle_on && ($urandom_range(99) < 16)) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = b;
        i_s_axis_tlast  = last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_byte_text(b, last);
        bytes_sent++;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    // Hold until every predicted character has gone out, then let the pipe settle.
    task automatic wait_drained();
        while (dump_text_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_columns(input logic [7:0] cols);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_data  = cols;
        do @(posedge i_clk); while (!o_cfg_ready);
        cols_per_line = cols;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_message(input int len);
        for (int k = 0; k < len; k++)
            send_byte(8'($urandom), k == len - 1);
    endtask

    // Reset value of 16 columns, with the extreme byte values on one line.
    task automatic test_default_columns();
        logic [7:0] pattern[17];
        pattern = '{8'h00, 8'hFF, 8'h09, 8'h0A, 8'h90, 8'hA0, 8'h0F, 8'hF0, 8'h5A,
                    8'hA5, 8'h3C, 8'hC3, 8'h12, 8'hED, 8'h7F, 8'h80, 8'h01};
        for (int k = 0; k < 17; k++)
            send_byte(pattern[k], k == 16);
    endtask

    task automatic test_one_byte_message();
        send_byte(8'hB6, 1'b1);
    endtask

    task automatic test_single_column();
        write_columns(8'd1);
        send_byte(8'hC4, 1'b0);
        send_byte(8'h3E, 1'b0);
        send_byte(8'hD7, 1'b1);
    endtask

    // Lower the register while a line is half full: the next byte must break.
    task automatic test_lowered_mid_line();
        write_columns(8'd8);
        for (int k = 0; k < 4; k++) send_byte(8'($urandom), 1'b0);
        write_columns(8'd2);
        send_byte(8'h6B, 1'b0);
        send_byte(8'h29, 1'b1);
    endtask

    // Widest lines: zero means 256 columns, so the break comes after byte 256.
    // Both sides stream flat out for this whole stretch.
    task automatic test_widest_lines();
        write_columns(8'd0);
        idle_on = 1'b0;
        send_message(257);
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int sent;
        int phase;
        int quota;
        int len;
        int sel;
        logic [7:0] cols;
        sent  = 0;
        phase = 0;
        while (sent < 45) begin
            sel = $urandom_range(9);
            case (sel)
                0:       cols = 8'd1;
                1:       cols = 8'd2;
                2:       cols = 8'd3;
                3:       cols = 8'($urandom);
                default: cols = 8'($urandom_range(1, 20));
            endcase
            write_columns(cols);
            // One phase runs with both sides streaming flat out.
            idle_on = (phase != 2);
            quota   = 15;
            while (quota > 0) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                if (len > quota) len = quota;
                // Mostly complete messages; sometimes leave one open across the register write.
                if ($urandom_range(5) == 0) begin
                    for (int k = 0; k < len; k++) send_byte(8'($urandom), 1'b0);
                end else begin
                    send_message(len);
                end
                quota -= len;
                sent  += len;
            end
            idle_on = 1'b1;
            phase++;
        end
    endtask

    initial begin
        mismatches      = 0;
        bytes_sent      = 0;
        chars_checked   = 0;
        cfg_writes      = 0;
        idle_on         = 1'b1;
        cols_per_line   = COLS_RESET;
        line_pos        = 8'd0;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = 8'd0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'd0;
        i_s_axis_tlast  = 1'b0;
        i_m_axis_tready = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_default_columns();
        test_one_byte_message();
        test_single_column();
        test_lowered_mid_line();
        test_widest_lines();
        test_random_traffic();

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (dump_text_q.size() != 0)
            report_mismatch($sformatf("%0d chars never arrived", dump_text_q.size()));
        $display("Summary: %0d bytes in, %0d chars checked, %0d column writes",
                 bytes_sent, chars_checked, cfg_writes);
        $display("Lines of 16, 1, 8 cut to 2 mid-line, 0 read as 256 and random widths,");
        $display("with random stalls on both sides and one long stall-free stretch");
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== hex_dump_line_formatter.f =====
rtl/hdlf_pkg.sv
rtl/hdlf_encode.sv
rtl/hex_dump_line_formatter.sv
rtl/hdlf_checker.sv
verif/tb_hex_dump_line_formatter.sv
